// ===== rtl/core/irans_pkg.sv =====
`default_nettype none

package irans_pkg;

  localparam int LANES         = 32;
  localparam int ALPHABET      = 256;
  localparam int MIN_PROB_BITS = 10;
  localparam int SYM_W         = 8;
  // running sum of 256 sixteen-bit frequencies
  localparam int SUM_W         = 24;

  localparam logic [3:0] PROB_BITS_RESET = 4'd15;

  // one-bit register index taken from paddr[2]
  localparam logic REG_PROB_BITS    = 1'b0;
  localparam logic REG_TOTAL_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    MODE_LOAD_FREQ = 2'd0,
    MODE_BUILD     = 2'd1,
    MODE_LOAD_LANE = 2'd2,
    MODE_DECODE    = 2'd3
  } irans_mode_e;

  // output position of each lane within a group
  localparam logic [4:0] LANE_PERM [LANES] = '{
    5'h00, 5'h01, 5'h02, 5'h03, 5'h10, 5'h11, 5'h12, 5'h13,
    5'h04, 5'h05, 5'h06, 5'h07, 5'h14, 5'h15, 5'h16, 5'h17,
    5'h08, 5'h09, 5'h0A, 5'h0B, 5'h18, 5'h19, 5'h1A, 5'h1B,
    5'h0C, 5'h0D, 5'h0E, 5'h0F, 5'h1C, 5'h1D, 5'h1E, 5'h1F
  };

endpackage

`default_nettype wire

// ===== rtl/core/interleaved_rans_decoder.sv =====
// Interleaved rANS decoder, 32 lanes, 16-bit renormalisation.
// Input stream: s_axis_tuser carries the mode, s_axis_tdata the entry index, load value
// and next stream word. Every input transfer gives exactly one output transfer.
// Modes: load one frequency, build the cumulative and slot tables, load one lane state,
// decode one symbol with the lane in turn (the result says whether the word was used).
// The user sets prob_bits and total_length over APB only while idle; not enforced here.
// Path per item (accept to result in the output register):
//   load frequency, load lane, skipped position: straight from idle to the done state
//   decode: the chain lane RAM -> slot RAM -> frequency/cumulative RAM ->
//   multiply -> update, each memory read registered
//   build: every slot of the slot RAM is rewritten, one per cycle in the fill states,
//   unused slots cleared to symbol 0
// One item is in flight at a time; the next is taken once the previous result sits
// in the output register, even if the receiver has not yet taken it. A stalled
// receiver holds the result; an item that finishes meanwhile waits for the register.
// Reset clears the lane counter, group base, error flag and registers; the memory
// contents stay undefined until loaded or built.
`default_nettype none

module interleaved_rans_decoder
  import irans_pkg::*;
#(
  parameter int MAX_PROB_BITS = 15
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // stream in
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // [7:0] entry_index, [39:8] load_value, [55:40] next_word
  input  wire logic [55:0] s_axis_tdata,
  // [1:0] mode
  input  wire logic [1:0]  s_axis_tuser,
  // stream out
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] symbol, [39:8] position, [40] word_consumed, [41] table_error
  output      logic [47:0] m_axis_tdata,
  // [0] symbol_valid
  output      logic        m_axis_tuser,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam int SLOT_W = MAX_PROB_BITS;
  localparam int SLOTS  = 1 << SLOT_W;
  localparam int FILL_W = SLOT_W + 1;
  localparam int HI_W   = 32 - MIN_PROB_BITS;
  localparam int LANE_W = $clog2(LANES);
  localparam int IDX_W  = $clog2(ALPHABET);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BLD_RD,
    ST_BLD_SUM,
    ST_BLD_FILL,
    ST_BLD_TAIL,
    ST_DEC_SLOT,
    ST_DEC_SYM,
    ST_DEC_MUL,
    ST_DEC_UPD,
    ST_DONE
  } state_e;

  // configuration registers
  logic [3:0]  prob_bits_q;
  logic [31:0] total_length_q;

  // control and payload
  state_e              state_q;
  logic [LANE_W-1:0]   lane_counter_q;
  logic [31:0]         group_base_q;
  logic                tables_bad_q;
  logic [LANE_W-1:0]   lane_q;
  logic [15:0]         word_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [HI_W-1:0]     hi_q;
  logic [SYM_W-1:0]    sym_q;
  logic [31:0]         prod_q;
  logic [15:0]         cumul_q;
  logic [IDX_W-1:0]    bld_sym_q;
  logic [SUM_W-1:0]    sum_q;
  logic [FILL_W-1:0]   fill_q;
  logic [FILL_W-1:0]   limit_q;
  logic [SYM_W-1:0]    res_symbol_q;
  logic [31:0]         res_position_q;
  logic                res_valid_q;
  logic                res_consumed_q;
  logic                out_valid_q;
  logic [47:0]         out_data_q;
  logic                out_user_q;

  // memories and registered read data
  logic [31:0]       lane_mem  [LANES];
  logic [15:0]       freq_mem  [ALPHABET];
  logic [15:0]       cumul_mem [ALPHABET];
  logic [SYM_W-1:0]  slot_mem  [SLOTS];
  logic [31:0]       lane_rdata_q;
  logic [15:0]       freq_rdata_q;
  logic [15:0]       cumul_rdata_q;
  logic [SYM_W-1:0]  slot_rdata_q;

  // input fields
  irans_mode_e       in_mode;
  logic [IDX_W-1:0]  in_index;
  logic [31:0]       in_value;
  logic [15:0]       in_word;
  logic              in_acc;
  logic              lane_ok;

  logic [3:0]        eff_bits;
  logic [SLOT_W-1:0] slot_mask;
  logic [SLOT_W-1:0] slot_raddr;
  logic [FILL_W-1:0] total;
  logic [SUM_W-1:0]  end_sum;
  logic [FILL_W-1:0] end_clip;
  logic [32:0]       pos;
  logic              skip;
  logic [31:0]       upd;
  logic              renorm;
  logic [31:0]       new_state;

  logic              lane_we;
  logic [LANE_W-1:0] lane_waddr;
  logic [31:0]       lane_wdata;
  logic              freq_we;
  logic [IDX_W-1:0]  freq_raddr;
  logic              cumul_we;
  logic              slot_we;
  logic [SYM_W-1:0]  slot_wdata;
  logic              fill_more;
  logic              cfg_we;

  assign in_mode  = irans_mode_e'(s_axis_tuser);
  assign in_index = s_axis_tdata[7:0];
  assign in_value = s_axis_tdata[39:8];
  assign in_word  = s_axis_tdata[55:40];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign lane_ok       = (in_index[IDX_W-1:LANE_W] == '0);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // prob_bits clamped to the supported range
  always_comb begin
    if (prob_bits_q < 4'(MIN_PROB_BITS)) begin
      eff_bits = 4'(MIN_PROB_BITS);
    end else if (prob_bits_q > 4'(MAX_PROB_BITS)) begin
      eff_bits = 4'(MAX_PROB_BITS);
    end else begin
      eff_bits = prob_bits_q;
    end
  end

  assign slot_mask  = ~({SLOT_W{1'b1}} << eff_bits);
  assign slot_raddr = lane_rdata_q[SLOT_W-1:0] & slot_mask;
  assign total      = FILL_W'(1) << eff_bits;

  assign end_sum  = sum_q + SUM_W'(freq_rdata_q);
  assign end_clip = (end_sum > SUM_W'(total)) ? total : end_sum[FILL_W-1:0];

  assign pos  = {1'b0, group_base_q} + 33'(LANE_PERM[lane_counter_q]);
  assign skip = (pos >= {1'b0, total_length_q});

  assign upd       = prod_q + 32'(slot_q) - 32'(cumul_q);
  assign renorm    = (upd[31:16] == '0);
  assign new_state = renorm ? {upd[15:0], word_q} : upd;

  // memory port control
  assign lane_we    = (in_acc && (in_mode == MODE_LOAD_LANE) && lane_ok) ||
                      (state_q == ST_DEC_UPD);
  assign lane_waddr = (state_q == ST_DEC_UPD) ? lane_q : in_index[LANE_W-1:0];
  assign lane_wdata = (state_q == ST_DEC_UPD) ? new_state : in_value;

  assign freq_we    = in_acc && (in_mode == MODE_LOAD_FREQ);
  assign freq_raddr = (state_q == ST_DEC_SYM) ? slot_rdata_q : bld_sym_q;
  assign cumul_we   = (state_q == ST_BLD_SUM);

  assign fill_more  = (fill_q < limit_q);
  assign slot_we    = ((state_q == ST_BLD_FILL) && fill_more) ||
                      ((state_q == ST_BLD_TAIL) && !fill_q[SLOT_W]);
  assign slot_wdata = (state_q == ST_BLD_FILL) ? bld_sym_q : '0;

  always_ff @(posedge clk_i) begin
    if (lane_we) begin
      lane_mem[lane_waddr] <= lane_wdata;
    end
    lane_rdata_q <= lane_mem[lane_counter_q];
  end

  always_ff @(posedge clk_i) begin
    if (freq_we) begin
      freq_mem[in_index] <= in_value[15:0];
    end
    freq_rdata_q <= freq_mem[freq_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cumul_we) begin
      cumul_mem[bld_sym_q] <= sum_q[15:0];
    end
    cumul_rdata_q <= cumul_mem[slot_rdata_q];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[fill_q[SLOT_W-1:0]] <= slot_wdata;
    end
    slot_rdata_q <= slot_mem[slot_raddr];
  end

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_TOTAL_LENGTH) ? total_length_q : {28'b0, prob_bits_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prob_bits_q    <= PROB_BITS_RESET;
      total_length_q <= '0;
    end else if (cfg_we) begin
      if (paddr[2] == REG_PROB_BITS) begin
        prob_bits_q <= pwdata[3:0];
      end else begin
        total_length_q <= pwdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      lane_counter_q <= '0;
      group_base_q   <= '0;
      tables_bad_q   <= 1'b0;
      lane_q         <= '0;
      word_q         <= '0;
      slot_q         <= '0;
      hi_q           <= '0;
      sym_q          <= '0;
      prod_q         <= '0;
      cumul_q        <= '0;
      bld_sym_q      <= '0;
      sum_q          <= '0;
      fill_q         <= '0;
      limit_q        <= '0;
      res_symbol_q   <= '0;
      res_position_q <= '0;
      res_valid_q    <= 1'b0;
      res_consumed_q <= 1'b0;
      out_valid_q    <= 1'b0;
      out_data_q     <= '0;
      out_user_q     <= 1'b0;
    end else begin
      // in ST_DONE the output register is refilled instead
      if (out_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            res_symbol_q   <= '0;
            res_position_q <= (in_mode == MODE_DECODE) ? pos[31:0] : '0;
            res_valid_q    <= 1'b0;
            res_consumed_q <= 1'b0;
            case (in_mode)
              MODE_LOAD_FREQ: begin
                state_q <= ST_DONE;
              end
              MODE_BUILD: begin
                bld_sym_q <= '0;
                sum_q     <= '0;
                fill_q    <= '0;
                state_q   <= ST_BLD_RD;
              end
              MODE_LOAD_LANE: begin
                if (lane_ok) begin
                  lane_counter_q <= '0;
                  group_base_q   <= '0;
                end
                state_q <= ST_DONE;
              end
              MODE_DECODE: begin
                lane_q         <= lane_counter_q;
                word_q         <= in_word;
                lane_counter_q <= lane_counter_q + 1'b1;
                if (lane_counter_q == LANE_W'(LANES - 1)) begin
                  group_base_q <= group_base_q + 32'(LANES);
                end
                state_q <= skip ? ST_DONE : ST_DEC_SLOT;
              end
              default: begin
                state_q <= ST_DONE;
              end
            endcase
          end
        end

        // build: one symbol per pass, one slot per cycle while in the fill state
        ST_BLD_RD: begin
          state_q <= ST_BLD_SUM;
        end
        ST_BLD_SUM: begin
          limit_q <= end_clip;
          sum_q   <= end_sum;
          state_q <= ST_BLD_FILL;
        end
        ST_BLD_FILL: begin
          if (fill_more) begin
            fill_q <= fill_q + 1'b1;
          end else if (bld_sym_q == IDX_W'(ALPHABET - 1)) begin
            state_q <= ST_BLD_TAIL;
          end else begin
            bld_sym_q <= bld_sym_q + 1'b1;
            state_q   <= ST_BLD_RD;
          end
        end
        ST_BLD_TAIL: begin
          if (!fill_q[SLOT_W]) begin
            fill_q <= fill_q + 1'b1;
          end else begin
            tables_bad_q <= (sum_q != SUM_W'(total));
            state_q      <= ST_DONE;
          end
        end

        // decode
        ST_DEC_SLOT: begin
          slot_q  <= slot_raddr;
          hi_q    <= HI_W'(lane_rdata_q >> eff_bits);
          state_q <= ST_DEC_SYM;
        end
        ST_DEC_SYM: begin
          sym_q   <= slot_rdata_q;
          state_q <= ST_DEC_MUL;
        end
        ST_DEC_MUL: begin
          prod_q  <= 32'(hi_q) * 32'(freq_rdata_q);
          cumul_q <= cumul_rdata_q;
          state_q <= ST_DEC_UPD;
        end
        ST_DEC_UPD: begin
          res_symbol_q   <= sym_q;
          res_valid_q    <= 1'b1;
          res_consumed_q <= renorm;
          state_q        <= ST_DONE;
        end

        ST_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {6'b0, tables_bad_q, res_consumed_q, res_position_q,
                            res_symbol_q};
            out_user_q  <= res_valid_q;
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // one item in flight: no accept directly after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input accepted while an item is still in flight");

  // a decode always moves on to the next lane
  a_lane_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_mode == MODE_DECODE)) |=>
      (lane_counter_q == LANE_W'($past(lane_counter_q) + 1'b1)))
    else $error("lane counter did not advance on decode");

  // a valid lane load restarts the rotation
  a_lane_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_mode == MODE_LOAD_LANE) && lane_ok) |=>
      ((lane_counter_q == '0) && (group_base_q == '0)))
    else $error("lane load did not restart the rotation");

  // the word can only be used by a decoded symbol
  a_consumed_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[40]) |-> out_user_q)
    else $error("word consumed without a decoded symbol");
`endif

endmodule

`default_nettype wire
